@@ sv/kdlr_pkg.sv @@
// Package: shared constants, types and code table for the key debounce unit.
`timescale 1ns / 1ps
package kdlr_pkg;

  // Fixed field widths
  localparam int PIN_BITS      = 4;
  localparam int CODE_W        = 4;
  localparam int FILTER_W      = 7;
  localparam int FCOUNT_W      = 8;
  localparam int LONG_W        = 16;
  localparam int REPEAT_W      = 8;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 16;

  // Defaults
  localparam int KEYS_DEFAULT  = 4;
  localparam int QUEUE_DEPTH   = 2;

  // Register reset values
  localparam logic [FILTER_W-1:0] FILTER_TIME_RST  = FILTER_W'(5);
  localparam logic [LONG_W-1:0]   LONG_TIME_RST    = LONG_W'(100);
  localparam logic [REPEAT_W-1:0] REPEAT_SPEED_RST = REPEAT_W'(5);
  localparam logic [PIN_BITS-1:0] ACTIVE_MASK_RST  = PIN_BITS'(1);

  // Filter counter starts at half the reset filter time
  localparam logic [FCOUNT_W-1:0] FCOUNT_RST = FCOUNT_W'(5 / 2);

  // Register indexes on the write port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FILTER_TIME  = 2'd0,
    REG_LONG_TIME    = 2'd1,
    REG_REPEAT_SPEED = 2'd2,
    REG_ACTIVE_MASK  = 2'd3
  } reg_idx_t;

  // Event slots per key, in emission order
  localparam int EV_PRESS   = 0;
  localparam int EV_LONG    = 1;
  localparam int EV_REPEAT  = 2;
  localparam int EV_RELEASE = 3;
  localparam int EV_PER_KEY = 4;

  // Code offsets from 3*key
  localparam int OFS_PRESS   = 1;
  localparam int OFS_RELEASE = 2;
  localparam int OFS_LONG    = 3;

  typedef struct packed {
    logic [FILTER_W-1:0] filter_time;
    logic [LONG_W-1:0]   long_time;
    logic [REPEAT_W-1:0] repeat_speed;
    logic [PIN_BITS-1:0] active_high_mask;
  } cfg_t;

  // Key code for event slot number i (key = i / EV_PER_KEY)
  function automatic logic [CODE_W-1:0] code_of(input int i);
    int k;
    int kind;
    int ofs;
    k    = i / EV_PER_KEY;
    kind = i % EV_PER_KEY;
    case (kind)
      EV_LONG:    ofs = OFS_LONG;
      EV_RELEASE: ofs = OFS_RELEASE;
      default:    ofs = OFS_PRESS;
    endcase
    return CODE_W'(3 * k + ofs);
  endfunction

endpackage

@@ sv/kdlr_front.sv @@
// Front end: per-key debounce, long-press and repeat counters; turns a tick into events.
`timescale 1ns / 1ps
module kdlr_front #(
  parameter int KEYS = kdlr_pkg::KEYS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kdlr_pkg::cfg_t                 cfg,
  input  logic                           accept,
  input  logic [kdlr_pkg::PIN_BITS-1:0]  pin_levels,
  output logic [kdlr_pkg::EV_PER_KEY*KEYS-1:0] events,
  output logic                           has_events
);

  logic [kdlr_pkg::PIN_BITS-1:0] down_bits;
  logic [kdlr_pkg::FCOUNT_W-1:0] ft8;
  logic [kdlr_pkg::FCOUNT_W-1:0] top8;

  // Pressed bits and the filter range
  assign down_bits  = ~(pin_levels ^ cfg.active_high_mask);
  assign ft8        = {1'b0, cfg.filter_time};
  assign top8       = {cfg.filter_time, 1'b0};
  assign has_events = |events;

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    logic                          down;
    logic [kdlr_pkg::FCOUNT_W-1:0] fcnt, fcnt_next;
    logic                          pflag, pflag_next;
    logic [kdlr_pkg::LONG_W-1:0]   lcnt, lcnt_next;
    logic [kdlr_pkg::REPEAT_W-1:0] rcnt, rcnt_next;
    logic [kdlr_pkg::LONG_W:0]     lcnt_inc;
    logic [kdlr_pkg::REPEAT_W:0]   rcnt_inc;
    logic                          ev_press, ev_long, ev_rep, ev_rel;

    // Keys past the pin word never read as pressed
    if (k < kdlr_pkg::PIN_BITS) begin : g_pin
      assign down = down_bits[k];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    assign lcnt_inc = {1'b0, lcnt} + 1'b1;
    assign rcnt_inc = {1'b0, rcnt} + 1'b1;

    // Next counter values and events for this tick
    always_comb begin
      fcnt_next  = fcnt;
      pflag_next = pflag;
      lcnt_next  = lcnt;
      rcnt_next  = rcnt;
      ev_press   = 1'b0;
      ev_long    = 1'b0;
      ev_rep     = 1'b0;
      ev_rel     = 1'b0;
      if (down) begin
        if (fcnt < ft8) begin
          fcnt_next = ft8;
        end else if (fcnt < top8) begin
          fcnt_next = fcnt + 1'b1;
        end else begin
          if (!pflag) begin
            pflag_next = 1'b1;
            ev_press   = 1'b1;
          end
          if (cfg.long_time != '0) begin
            if (lcnt < cfg.long_time) begin
              lcnt_next = lcnt_inc[kdlr_pkg::LONG_W-1:0];
              ev_long   = (lcnt_inc == {1'b0, cfg.long_time});
            end else if (cfg.repeat_speed != '0) begin
              if (rcnt_inc >= {1'b0, cfg.repeat_speed}) begin
                rcnt_next = '0;
                ev_rep    = 1'b1;
              end else begin
                rcnt_next = rcnt_inc[kdlr_pkg::REPEAT_W-1:0];
              end
            end
          end
        end
      end else begin
        if (fcnt > ft8) begin
          fcnt_next = ft8;
        end else if (fcnt != '0) begin
          fcnt_next = fcnt - 1'b1;
        end else if (pflag) begin
          pflag_next = 1'b0;
          ev_rel     = 1'b1;
        end
        lcnt_next = '0;
        rcnt_next = '0;
      end
    end

    // State advances only on an accepted tick
    always_ff @(posedge clk) begin
      if (rst) begin
        fcnt  <= kdlr_pkg::FCOUNT_RST;
        pflag <= 1'b0;
        lcnt  <= '0;
        rcnt  <= '0;
      end else if (accept) begin
        fcnt  <= fcnt_next;
        pflag <= pflag_next;
        lcnt  <= lcnt_next;
        rcnt  <= rcnt_next;
      end
    end

    assign events[k*kdlr_pkg::EV_PER_KEY + kdlr_pkg::EV_PRESS]   = ev_press;
    assign events[k*kdlr_pkg::EV_PER_KEY + kdlr_pkg::EV_LONG]    = ev_long;
    assign events[k*kdlr_pkg::EV_PER_KEY + kdlr_pkg::EV_REPEAT]  = ev_rep;
    assign events[k*kdlr_pkg::EV_PER_KEY + kdlr_pkg::EV_RELEASE] = ev_rel;
  end

endmodule

@@ sv/kdlr_fifo.sv @@
// Small flop-based queue of event vectors between front and back end.
`timescale 1ns / 1ps
module kdlr_fifo #(
  parameter int WIDTH = kdlr_pkg::EV_PER_KEY * kdlr_pkg::KEYS_DEFAULT,
  parameter int DEPTH = kdlr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] din,
  input  logic             rd,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/kdlr_back.sv @@
// Back end: serializes one event vector into key codes through an output register.
`timescale 1ns / 1ps
module kdlr_back #(
  parameter int KEYS = kdlr_pkg::KEYS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  logic [kdlr_pkg::EV_PER_KEY*KEYS-1:0] q_data,
  output logic                                 q_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output logic [kdlr_pkg::CODE_W-1:0]          key_code,
  output logic                                 last
);

  localparam int EV_W = kdlr_pkg::EV_PER_KEY * KEYS;

  logic [EV_W-1:0]             cur, cur_clr, sel_bit;
  logic                        out_valid;
  logic                        emit;
  logic [kdlr_pkg::CODE_W-1:0] sel_code;

  // Lowest pending event goes first
  assign sel_bit = cur & (~cur + 1'b1);
  assign emit    = (cur != '0) && (!out_valid || pop);
  assign cur_clr = emit ? (cur & ~sel_bit) : cur;
  assign q_pop   = (cur_clr == '0) && !q_empty;
  assign empty   = !out_valid;

  // Code of the selected event
  always_comb begin
    sel_code = '0;
    for (int i = 0; i < EV_W; i++) begin
      if (sel_bit[i]) begin
        sel_code = sel_code | kdlr_pkg::code_of(i);
      end
    end
  end

  // Working vector: refilled from the queue as soon as it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (q_pop) begin
      cur <= q_data;
    end else begin
      cur <= cur_clr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      key_code <= sel_code;
      last     <= (cur_clr == '0);
    end
  end

endmodule

@@ sv/key_debounce_long_repeat_unit.sv @@
// Key debounce unit: a tick's events pass the event queue, working vector and
// output register. Results leave at one code per cycle while pop is held; a
// tick is accepted every cycle while the two-entry event queue has room, so
// the result port sets the rate. A tick that causes no code produces no result.
// Synchronous reset: registers to defaults, filter counters to 2, no results.
`timescale 1ns / 1ps
module key_debounce_long_repeat_unit #(
  parameter int KEYS = kdlr_pkg::KEYS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [kdlr_pkg::PIN_BITS-1:0]    pin_levels,
  output logic                             empty,
  input  logic                             pop,
  output logic [kdlr_pkg::CODE_W-1:0]      key_code,
  output logic                             last,
  input  logic                             cfg_wr_en,
  input  logic [kdlr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kdlr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int EV_W = kdlr_pkg::EV_PER_KEY * KEYS;

  kdlr_pkg::cfg_t  cfg;
  logic            accept;
  logic [EV_W-1:0] events, q_data;
  logic            has_events;
  logic            q_full, q_empty, q_pop;

  assign accept = push && !full;
  assign full   = q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_time      <= kdlr_pkg::FILTER_TIME_RST;
      cfg.long_time        <= kdlr_pkg::LONG_TIME_RST;
      cfg.repeat_speed     <= kdlr_pkg::REPEAT_SPEED_RST;
      cfg.active_high_mask <= kdlr_pkg::ACTIVE_MASK_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        kdlr_pkg::REG_FILTER_TIME:
          cfg.filter_time <= cfg_data[kdlr_pkg::FILTER_W-1:0];
        kdlr_pkg::REG_LONG_TIME:
          cfg.long_time <= cfg_data[kdlr_pkg::LONG_W-1:0];
        kdlr_pkg::REG_REPEAT_SPEED:
          cfg.repeat_speed <= cfg_data[kdlr_pkg::REPEAT_W-1:0];
        kdlr_pkg::REG_ACTIVE_MASK:
          cfg.active_high_mask <= cfg_data[kdlr_pkg::PIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  kdlr_front #(.KEYS(KEYS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .pin_levels (pin_levels),
    .events     (events),
    .has_events (has_events)
  );

  kdlr_fifo #(.WIDTH(EV_W), .DEPTH(kdlr_pkg::QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept && has_events),
    .din   (events),
    .rd    (q_pop),
    .dout  (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  kdlr_back #(.KEYS(KEYS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .key_code (key_code),
    .last     (last)
  );

endmodule

@@ sv/kdlr_checker.sv @@
// Port-level checker for the key debounce unit, bound to the top level.
`timescale 1ns / 1ps
module kdlr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [kdlr_pkg::CODE_W-1:0] key_code,
  input logic                        last
);

  // A waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(key_code) && $stable(last)))
    else $error("result changed before pop");

  // Codes come from real keys only
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (key_code != '0 && key_code <= kdlr_pkg::CODE_W'(12)))
    else $error("key code out of range");

  // Reset leaves no result behind
  a_rst_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result present after reset");

  // Reset leaves the queue with room
  a_rst_full: assert property (@(posedge clk)
    rst |=> !full)
    else $error("input full after reset");

endmodule

bind key_debounce_long_repeat_unit kdlr_checker u_kdlr_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .key_code (key_code),
  .last     (last)
);

@@ test/tb_key_debounce_long_repeat_unit.sv @@
// Self-checking testbench for the key debounce unit: directed table, then random key holds.
`timescale 1ns / 1ps
module tb_key_debounce_long_repeat_unit;
  import kdlr_pkg::*;

  localparam int NUM_KEYS      = KEYS_DEFAULT;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PREDICT       = -1;

  // Key codes used by the typed rows of the directed table
  localparam logic [CODE_W-1:0] PRESS_K0 = CODE_W'(0 + OFS_PRESS);
  localparam logic [CODE_W-1:0] PRESS_K1 = CODE_W'(3 + OFS_PRESS);
  localparam logic [CODE_W-1:0] PRESS_K2 = CODE_W'(6 + OFS_PRESS);
  localparam logic [CODE_W-1:0] PRESS_K3 = CODE_W'(9 + OFS_PRESS);
  localparam logic [CODE_W-1:0] LONG_K0  = CODE_W'(0 + OFS_LONG);
  localparam logic [CODE_W-1:0] LONG_K1  = CODE_W'(3 + OFS_LONG);
  localparam logic [CODE_W-1:0] LONG_K2  = CODE_W'(6 + OFS_LONG);
  localparam logic [CODE_W-1:0] LONG_K3  = CODE_W'(9 + OFS_LONG);
  localparam logic [CODE_W-1:0] REL_K0   = CODE_W'(0 + OFS_RELEASE);
  localparam logic [CODE_W-1:0] REL_K1   = CODE_W'(3 + OFS_RELEASE);
  localparam logic [CODE_W-1:0] REL_K2   = CODE_W'(6 + OFS_RELEASE);
  localparam logic [CODE_W-1:0] REL_K3   = CODE_W'(9 + OFS_RELEASE);

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    reg_idx_t                  addr;
    logic [CFG_DATA_W-1:0]     value;
    int                        n_typed;
    logic [0:7][CODE_W-1:0]    typed;
  } dir_row_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } key_event_t;

  localparam int NUM_DIR = 38;
  localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
    // quiet tick right after reset
    '{ROW_TICK,  REG_FILTER_TIME,  16'hE, 0, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    // filter time zero, press and long in one tick
    '{ROW_WRITE, REG_FILTER_TIME,  16'd0, PREDICT, '0},
    '{ROW_WRITE, REG_LONG_TIME,    16'd1, PREDICT, '0},
    '{ROW_WRITE, REG_REPEAT_SPEED, 16'd1, PREDICT, '0},
    '{ROW_WRITE, REG_ACTIVE_MASK,  16'h0, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'h0, 8,
      {PRESS_K0, LONG_K0, PRESS_K1, LONG_K1, PRESS_K2, LONG_K2, PRESS_K3, LONG_K3}},
    '{ROW_TICK,  REG_FILTER_TIME,  16'h0, 4, {PRESS_K0, PRESS_K1, PRESS_K2, PRESS_K3, 16'h0}},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, 4, {REL_K0, REL_K1, REL_K2, REL_K3, 16'h0}},
    // long hold, then long time lowered below the running count
    '{ROW_WRITE, REG_FILTER_TIME,  16'd1, PREDICT, '0},
    '{ROW_WRITE, REG_LONG_TIME,    16'd200, PREDICT, '0},
    '{ROW_WRITE, REG_REPEAT_SPEED, 16'd3, PREDICT, '0},
    '{ROW_WRITE, REG_ACTIVE_MASK,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_WRITE, REG_LONG_TIME,    16'd2, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    // repeat speed lowered to the running count, then disabled
    '{ROW_WRITE, REG_REPEAT_SPEED, 16'd1, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    '{ROW_WRITE, REG_REPEAT_SPEED, 16'd0, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hF, PREDICT, '0},
    // filter time, long time and repeat speed at their maxima
    '{ROW_WRITE, REG_FILTER_TIME,  16'd127, PREDICT, '0},
    '{ROW_WRITE, REG_LONG_TIME,    16'hFFFF, PREDICT, '0},
    '{ROW_WRITE, REG_REPEAT_SPEED, 16'd255, PREDICT, '0},
    '{ROW_WRITE, REG_ACTIVE_MASK,  16'h5, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'h5, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'hA, PREDICT, '0},
    '{ROW_TICK,  REG_FILTER_TIME,  16'h0, PREDICT, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [PIN_BITS-1:0]   pin_levels = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [CODE_W-1:0]     key_code;
  logic                  last;
  logic                  cfg_wr_en = 1'b0;
  reg_idx_t              cfg_addr = REG_FILTER_TIME;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and per-key state
  logic [FILTER_W-1:0]   cfg_filter;
  logic [LONG_W-1:0]     cfg_long;
  logic [REPEAT_W-1:0]   cfg_repeat;
  logic [PIN_BITS-1:0]   cfg_mask;
  logic [FCOUNT_W-1:0]   flt_cnt  [NUM_KEYS];
  logic                  held     [NUM_KEYS];
  logic [LONG_W-1:0]     hold_cnt [NUM_KEYS];
  logic [REPEAT_W-1:0]   rpt_cnt  [NUM_KEYS];

  logic [CODE_W-1:0]     tick_codes [0:7];
  int                    tick_n;
  key_event_t            pending_codes [$];
  int                    mismatches = 0;
  int                    cycle_count = 0;
  int                    pop_hold = 0;
  bit                    calm = 1'b0;

  key_debounce_long_repeat_unit #(.KEYS(NUM_KEYS)) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pin_levels (pin_levels),
    .empty      (empty),
    .pop        (pop),
    .key_code   (key_code),
    .last       (last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void add_code(input int c);
    tick_codes[tick_n] = CODE_W'(c);
    tick_n++;
  endfunction

  // Debounce, long press and repeat for one scan tick; codes land in tick_codes
  function automatic void scan_keys(input logic [PIN_BITS-1:0] lv);
    logic [PIN_BITS-1:0] down_bits;
    int cnt;
    int ft;
    int base;
    int r;
    down_bits = ~(lv ^ cfg_mask);
    ft = int'(cfg_filter);
    tick_n = 0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      base = 3 * k;
      cnt = int'(flt_cnt[k]);
      if (down_bits[k]) begin
        if (cnt < ft) begin
          flt_cnt[k] = FCOUNT_W'(ft);
        end else if (cnt < 2 * ft) begin
          flt_cnt[k] = FCOUNT_W'(cnt + 1);
        end else begin
          if (!held[k]) begin
            held[k] = 1'b1;
            add_code(base + OFS_PRESS);
          end
          if (cfg_long != 0) begin
            if (hold_cnt[k] < cfg_long) begin
              hold_cnt[k] = hold_cnt[k] + 1'b1;
              if (hold_cnt[k] == cfg_long) add_code(base + OFS_LONG);
            end else if (cfg_repeat != 0) begin
              r = int'(rpt_cnt[k]) + 1;
              if (r >= int'(cfg_repeat)) begin
                rpt_cnt[k] = '0;
                add_code(base + OFS_PRESS);
              end else begin
                rpt_cnt[k] = REPEAT_W'(r);
              end
            end
          end
        end
      end else begin
        if (cnt > ft) begin
          flt_cnt[k] = FCOUNT_W'(ft);
        end else if (cnt != 0) begin
          flt_cnt[k] = FCOUNT_W'(cnt - 1);
        end else if (held[k]) begin
          held[k] = 1'b0;
          add_code(base + OFS_RELEASE);
        end
        hold_cnt[k] = '0;
        rpt_cnt[k] = '0;
      end
    end
  endfunction

  // Drop the request line, wait out every pending code plus the pipeline
  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    drain_and_settle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FILTER_TIME:  cfg_filter = val[FILTER_W-1:0];
      REG_LONG_TIME:    cfg_long   = val[LONG_W-1:0];
      REG_REPEAT_SPEED: cfg_repeat = val[REPEAT_W-1:0];
      REG_ACTIVE_MASK:  cfg_mask   = val[PIN_BITS-1:0];
      default: ;
    endcase
  endtask

  // One scan request; typed codes replace the prediction when n_typed >= 0
  task automatic send_tick(input logic [PIN_BITS-1:0] lv, input int n_typed,
                           input logic [0:7][CODE_W-1:0] typed);
    key_event_t ev;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push       <= 1'b1;
    pin_levels <= lv;
    do @(posedge clk); while (full);
    scan_keys(lv);
    if (n_typed >= 0) begin
      for (int i = 0; i < n_typed; i++) begin
        ev.code = typed[i];
        ev.last = (i == n_typed - 1);
        pending_codes.push_back(ev);
      end
    end else begin
      for (int i = 0; i < tick_n; i++) begin
        ev.code = tick_codes[i];
        ev.last = (i == tick_n - 1);
        pending_codes.push_back(ev);
      end
    end
  endtask

  // Result side: check each popped code, then pick the next pop value
  always @(posedge clk) begin
    key_event_t want;
    if (!rst && pop && !empty) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected code, expected none, actual key_code %0d last %0b",
                 $time, key_code, last);
      end else begin
        want = pending_codes.pop_front();
        if (key_code !== want.code) begin
          mismatches++;
          $display("%0t: key_code expected %0d actual %0d", $time, want.code, key_code);
        end
        if (last !== want.last) begin
          mismatches++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        end
      end
    end
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 2);
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int span;
    int hold_len;
    int ticks_left;
    int flip;
    logic [PIN_BITS-1:0] hold_levels;
    logic [PIN_BITS-1:0] lv;

    cfg_filter = FILTER_TIME_RST;
    cfg_long   = LONG_TIME_RST;
    cfg_repeat = REPEAT_SPEED_RST;
    cfg_mask   = ACTIVE_MASK_RST;
    for (int k = 0; k < NUM_KEYS; k++) begin
      flt_cnt[k]  = FCOUNT_RST;
      held[k]     = 1'b0;
      hold_cnt[k] = '0;
      rpt_cnt[k]  = '0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_WRITE)
        write_reg(DIR_ROWS[i].addr, DIR_ROWS[i].value);
      else
        send_tick(DIR_ROWS[i].value[PIN_BITS-1:0], DIR_ROWS[i].n_typed, DIR_ROWS[i].typed);
    end

    // Random phases: fresh settings each phase, the last one without idling
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) calm = 1'b1;
      write_reg(REG_FILTER_TIME,
                CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4)));
      case ($urandom_range(0, 3))
        0:       write_reg(REG_LONG_TIME, CFG_DATA_W'(0));
        1:       write_reg(REG_LONG_TIME, CFG_DATA_W'(1));
        default: write_reg(REG_LONG_TIME, CFG_DATA_W'($urandom_range(2, 12)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_REPEAT_SPEED, CFG_DATA_W'(0));
        1:       write_reg(REG_REPEAT_SPEED, CFG_DATA_W'(1));
        default: write_reg(REG_REPEAT_SPEED, CFG_DATA_W'($urandom_range(2, 5)));
      endcase
      write_reg(REG_ACTIVE_MASK, CFG_DATA_W'($urandom_range(0, 15)));

      // Mostly steady holds long enough to debounce and repeat, some short ones and glitches
      ticks_left = (ph == 6) ? 33 : 34;
      while (ticks_left > 0) begin
        hold_levels = PIN_BITS'($urandom_range(0, 15));
        span = 2 * int'(cfg_filter) + int'(cfg_long) + 3 * int'(cfg_repeat) + 4;
        if (span > 30) span = 30;
        hold_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, span);
        for (int j = 0; j < hold_len && ticks_left > 0; j++) begin
          lv = hold_levels;
          if ($urandom_range(0, 9) == 0) begin
            flip = $urandom_range(0, PIN_BITS - 1);
            lv[flip] = ~lv[flip];
          end
          send_tick(lv, PREDICT, '0);
          ticks_left--;
        end
      end
    end

    drain_and_settle();
    if (mismatches == 0 && pending_codes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/kdlr_pkg.sv
sv/kdlr_front.sv
sv/kdlr_fifo.sv
sv/kdlr_back.sv
sv/key_debounce_long_repeat_unit.sv
sv/kdlr_checker.sv
test/tb_key_debounce_long_repeat_unit.sv
